[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define TPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/tpa_pkg.sv]
// ---------------------------------------------------------------------------
// tpa_pkg
// Types, sizes and codes of the two-pool bitmap slot allocator.
// ---------------------------------------------------------------------------
package tpa_pkg;

    localparam int SLOTS           = 64;
    localparam int BULK_SLOT_BYTES = 4096;
    localparam int CMD_SLOT_BYTES  = 64;
    localparam int ADDR_BITS       = 48;

    localparam int FIELD_W  = 48;
    localparam int SIDX_W   = 6;
    localparam int MAP_BITS = 8;
    localparam int BIT_W    = $clog2(MAP_BITS);
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int ROWS     = SLOTS / MAP_BITS;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MEM_AW   = ROW_W + 1;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    localparam logic [FIELD_W-1:0] BULK_STRIDE = FIELD_W'(BULK_SLOT_BYTES);
    localparam logic [FIELD_W-1:0] CMD_STRIDE  = FIELD_W'(CMD_SLOT_BYTES);
    localparam logic [FIELD_W-1:0] BULK_SPAN = FIELD_W'(64'(SLOTS) * 64'(BULK_SLOT_BYTES));
    localparam logic [FIELD_W-1:0] CMD_SPAN  = FIELD_W'(64'(SLOTS) * 64'(CMD_SLOT_BYTES));
    localparam logic [FIELD_W-1:0] ADDR_MASK =
        (ADDR_BITS >= FIELD_W) ? {FIELD_W{1'b1}}
                               : FIELD_W'((64'd1 << ADDR_BITS) - 64'd1);

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_CHECK = 2'd2
    } t_action;

    typedef enum logic {
        CFG_BULK_BASE = 1'b0,
        CFG_CMD_BASE  = 1'b1
    } t_cfg_index;

    function automatic logic [BIT_W-1:0] first_zero(input logic [MAP_BITS-1:0] row);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int b = MAP_BITS - 1; b >= 0; b--) begin
            if (!row[b]) begin
                pos = BIT_W'(b);
            end
        end
        return pos;
    endfunction

endpackage

[hw/rtl/two_pool_bitmap_slot_allocator.sv]
// ---------------------------------------------------------------------------
// two_pool_bitmap_slot_allocator
// First-fit slot allocator over two bitmap pools held in one byte-wide RAM.
// ---------------------------------------------------------------------------
// Allocate: DECODE issues the read of byte 0, SCAN reads one bitmap byte per
//   cycle and marks the first free slot, CALC forms its address, DONE hands on
//   the result; a full pool goes from SCAN to DONE. Free runs DECODE, RMW, DONE
//   (DECODE, DONE outside the pool), check DECODE, DONE. One item at a time: a
//   new input beat is taken only in IDLE, after DONE has registered the result.
// Reset: synchronous, active low; clears both bases and the per-row valid
//   bits, so every slot reads free right after reset with no clearing pass.
// ---------------------------------------------------------------------------
module two_pool_bitmap_slot_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [tpa_pkg::FIELD_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_action,
    input  logic                        i_pool,
    input  logic [tpa_pkg::FIELD_W-1:0] i_buffer_address,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_ok,
    output logic [tpa_pkg::SIDX_W-1:0]  o_slot_index,
    output logic [tpa_pkg::FIELD_W-1:0] o_slot_address
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_RMW    = 6'b001000,
        ST_CALC   = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [tpa_pkg::FIELD_W-1:0] r_bulk_base, r_cmd_base;
    tpa_pkg::t_action            r_act;
    logic                        r_pool;
    logic [tpa_pkg::FIELD_W-1:0] r_addr;
    logic [tpa_pkg::IDX_W-1:0]   r_idx;
    logic                        r_ok;
    logic [tpa_pkg::FIELD_W-1:0] r_res_addr;

    logic [tpa_pkg::ROW_W-1:0]   r_rd_row, r_rsp_row;
    logic                        r_issue_done, r_rsp_vld;

    logic [tpa_pkg::MAP_BITS-1:0] mem [0:tpa_pkg::MEM_DEPTH-1];
    logic [tpa_pkg::MAP_BITS-1:0] r_rd_data;
    logic                         r_rd_rowv;
    logic [tpa_pkg::MEM_DEPTH-1:0] r_row_vld;

    logic                        r_out_vld, r_out_ok;
    logic [tpa_pkg::SIDX_W-1:0]  r_out_idx;
    logic [tpa_pkg::FIELD_W-1:0] r_out_addr;

    logic                         w_re, w_we;
    logic [tpa_pkg::MEM_AW-1:0]   w_raddr, w_waddr;
    logic [tpa_pkg::ROW_W-1:0]    w_rd_row;
    logic [tpa_pkg::MAP_BITS-1:0] w_wdata, w_row;
    logic [tpa_pkg::BIT_W-1:0]    w_fz;

    logic [tpa_pkg::FIELD_W-1:0] w_base, w_span;
    logic [tpa_pkg::FIELD_W:0]   w_off;
    logic                        w_inside;
    logic [tpa_pkg::IDX_W-1:0]   w_free_idx;
    logic [tpa_pkg::ROW_W-1:0]   w_free_row, w_idx_row;
    logic                        w_found, w_last, w_out_free;

    assign o_cfg_ready    = 1'b1;
    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_ok           = r_out_ok;
    assign o_slot_index   = r_out_idx;
    assign o_slot_address = r_out_addr;

    assign w_base     = r_pool ? r_cmd_base : r_bulk_base;
    assign w_span     = r_pool ? tpa_pkg::CMD_SPAN : tpa_pkg::BULK_SPAN;
    assign w_off      = {1'b0, r_addr} - {1'b0, w_base};
    assign w_inside   = !w_off[tpa_pkg::FIELD_W] && (w_off[tpa_pkg::FIELD_W-1:0] < w_span);
    assign w_free_idx = r_pool
        ? tpa_pkg::IDX_W'(w_off[tpa_pkg::FIELD_W-1:0] / tpa_pkg::CMD_STRIDE)
        : tpa_pkg::IDX_W'(w_off[tpa_pkg::FIELD_W-1:0] / tpa_pkg::BULK_STRIDE);
    assign w_free_row = tpa_pkg::ROW_W'(w_free_idx >> tpa_pkg::BIT_W);
    assign w_idx_row  = tpa_pkg::ROW_W'(r_idx >> tpa_pkg::BIT_W);

    assign w_row   = r_rd_rowv ? r_rd_data : '0;
    assign w_fz    = tpa_pkg::first_zero(w_row);
    assign w_found = r_rsp_vld && (w_row != {tpa_pkg::MAP_BITS{1'b1}});
    assign w_last  = (r_rsp_row == tpa_pkg::ROW_W'(tpa_pkg::ROWS - 1));
    assign w_out_free = !r_out_vld || i_out_ready;

    always_comb begin
        w_re     = 1'b0;
        w_rd_row = r_rd_row;
        w_we     = 1'b0;
        w_waddr  = {r_pool, w_idx_row};
        w_wdata  = w_row;
        n_state  = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (r_act == tpa_pkg::ACT_ALLOC) begin
                    w_re     = 1'b1;
                    w_rd_row = '0;
                    n_state  = ST_SCAN;
                end else if (r_act == tpa_pkg::ACT_FREE && w_inside) begin
                    w_re     = 1'b1;
                    w_rd_row = w_free_row;
                    n_state  = ST_RMW;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                w_re = !r_issue_done;
                if (w_found) begin
                    w_we    = 1'b1;
                    w_waddr = {r_pool, r_rsp_row};
                    w_wdata = w_row | (tpa_pkg::MAP_BITS'(1) << w_fz);
                    n_state = ST_CALC;
                end else if (r_rsp_vld && w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_RMW: begin
                w_we    = 1'b1;
                w_wdata = w_row & ~(tpa_pkg::MAP_BITS'(1) << r_idx[tpa_pkg::BIT_W-1:0]);
                n_state = ST_DONE;
            end
            ST_CALC: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        w_raddr = {r_pool, w_rd_row};
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_bulk_base  <= '0;
            r_cmd_base   <= '0;
            r_row_vld    <= '0;
            r_rd_rowv    <= 1'b0;
            r_rsp_vld    <= 1'b0;
            r_issue_done <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rsp_vld <= w_re;
            if (w_re) begin
                r_rd_rowv <= r_row_vld[w_raddr] && !(w_we && w_waddr == w_raddr);
            end
            if (w_we) begin
                r_row_vld[w_waddr] <= 1'b1;
            end
            if (i_cfg_valid) begin
                unique case (tpa_pkg::t_cfg_index'(i_cfg_index))
                    tpa_pkg::CFG_BULK_BASE: r_bulk_base <= i_cfg_data;
                    tpa_pkg::CFG_CMD_BASE:  r_cmd_base  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_re) begin
                r_issue_done <= (w_rd_row == tpa_pkg::ROW_W'(tpa_pkg::ROWS - 1));
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_row  <= w_rd_row + tpa_pkg::ROW_W'(1);
            r_rsp_row <= w_rd_row;
        end
        unique case (r_state)
            ST_IDLE: begin
                r_act  <= tpa_pkg::t_action'(i_action);
                r_pool <= i_pool;
                r_addr <= i_buffer_address;
            end
            ST_DECODE: begin
                r_res_addr <= '0;
                case (r_act)
                    tpa_pkg::ACT_FREE: begin
                        r_ok  <= w_inside;
                        r_idx <= w_inside ? w_free_idx : '0;
                    end
                    tpa_pkg::ACT_CHECK: begin
                        r_ok  <= w_inside;
                        r_idx <= '0;
                    end
                    default: begin
                        r_ok  <= 1'b0;
                        r_idx <= '0;
                    end
                endcase
            end
            ST_SCAN: begin
                if (w_found) begin
                    r_ok  <= 1'b1;
                    r_idx <= tpa_pkg::IDX_W'({r_rsp_row, w_fz});
                end
            end
            ST_CALC: begin
                r_res_addr <= (w_base + (r_pool
                    ? tpa_pkg::FIELD_W'(r_idx) * tpa_pkg::CMD_STRIDE
                    : tpa_pkg::FIELD_W'(r_idx) * tpa_pkg::BULK_STRIDE)) & tpa_pkg::ADDR_MASK;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_out_ok   <= r_ok;
                    r_out_idx  <= tpa_pkg::SIDX_W'(r_idx);
                    r_out_addr <= r_res_addr;
                end
            end
            default: ;
        endcase
    end

endmodule

[hw/rtl/tpa_checker.sv]
// ---------------------------------------------------------------------------
// tpa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tpa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_ok,
    input logic [tpa_pkg::SIDX_W-1:0]  o_slot_index,
    input logic [tpa_pkg::FIELD_W-1:0] o_slot_address
);

    logic                                        w_out_stall;
    logic                                        w_fail_beat;
    logic [tpa_pkg::SIDX_W+tpa_pkg::FIELD_W-1:0] w_out_rest;

    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_fail_beat = o_out_valid && !o_ok;
    assign w_out_rest  = {o_slot_index, o_slot_address};

    `TPA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_out_valid && $stable(o_ok) && $stable(w_out_rest))

    `TPA_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, w_fail_beat, w_out_rest == '0)

    `TPA_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind two_pool_bitmap_slot_allocator tpa_checker u_tpa_checker (.*);
